// ===== sv/assert_macros.svh =====
// Assertion macros used by the core RTL file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/colc_pkg.sv =====
// Types, character codes and limits for the CIGAR operation length counter.
package colc_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned CNT_W  = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;  // 'M'
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;  // '='
    localparam logic [CHAR_W-1:0] CH_X     = 8'h58;  // 'X'
    localparam logic [CHAR_W-1:0] CH_I     = 8'h49;  // 'I'
    localparam logic [CHAR_W-1:0] CH_S     = 8'h53;  // 'S'
    localparam logic [CHAR_W-1:0] CH_D     = 8'h44;  // 'D'
    localparam logic [CHAR_W-1:0] CH_N     = 8'h4E;  // 'N'
    localparam logic [CHAR_W-1:0] CH_H     = 8'h48;  // 'H'
    localparam logic [CHAR_W-1:0] CH_P     = 8'h50;  // 'P'

    // Operation class of a letter that closes a digit run.
    typedef enum logic [2:0] {
        OP_MATCH,
        OP_INSERT,
        OP_SOFTCLIP,
        OP_SKIP,
        OP_BAD
    } t_op;

    typedef struct packed {
        logic [CNT_W-1:0] run_length;
        logic             in_digits;
        logic [CNT_W-1:0] match_sum;
        logic [CNT_W-1:0] insert_sum;
        logic [CNT_W-1:0] softclip_sum;
        logic             error_seen;
        logic             overflow_seen;
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] match_total;
        logic [CNT_W-1:0] insert_total;
        logic [CNT_W-1:0] softclip_total;
        logic             parse_status;
        logic             saturated;
    } t_result;

endpackage

// ===== sv/colc_parse.sv =====
// Next-state and result logic for one CIGAR character or end marker.
module colc_parse (
    input  colc_pkg::t_state                  i_state,
    input  logic [colc_pkg::CHAR_W-1:0]       i_char,
    input  logic                              i_end,
    output colc_pkg::t_state                  o_state,
    output colc_pkg::t_result                 o_result
);

    colc_pkg::t_op                 w_op;
    logic                          w_is_digit;
    logic [colc_pkg::CNT_W+3:0]    w_run_wide;
    logic [colc_pkg::CNT_W-1:0]    w_sum_sel;
    logic [colc_pkg::CNT_W:0]      w_sum_wide;
    logic [colc_pkg::CNT_W-1:0]    w_sum_sat;
    logic                          w_sum_ovf;

    assign w_is_digit = (i_char >= colc_pkg::CH_ZERO) && (i_char <= colc_pkg::CH_NINE);

    always_comb begin
        case (i_char) inside
            colc_pkg::CH_M, colc_pkg::CH_EQ, colc_pkg::CH_X: w_op = colc_pkg::OP_MATCH;
            colc_pkg::CH_I:                                  w_op = colc_pkg::OP_INSERT;
            colc_pkg::CH_S:                                  w_op = colc_pkg::OP_SOFTCLIP;
            colc_pkg::CH_D, colc_pkg::CH_N,
            colc_pkg::CH_H, colc_pkg::CH_P:                  w_op = colc_pkg::OP_SKIP;
            default:                                         w_op = colc_pkg::OP_BAD;
        endcase
    end

    // run * 10 + digit as (run << 3) + (run << 1) + digit
    assign w_run_wide = ({4'b0, i_state.run_length} << 3)
                      + ({4'b0, i_state.run_length} << 1)
                      + {{colc_pkg::CNT_W{1'b0}}, i_char[3:0]};

    // One saturating adder, shared by the three totals.
    always_comb begin
        case (w_op)
            colc_pkg::OP_INSERT:   w_sum_sel = i_state.insert_sum;
            colc_pkg::OP_SOFTCLIP: w_sum_sel = i_state.softclip_sum;
            default:               w_sum_sel = i_state.match_sum;
        endcase
    end

    assign w_sum_wide = {1'b0, w_sum_sel} + {1'b0, i_state.run_length};
    assign w_sum_ovf  = w_sum_wide[colc_pkg::CNT_W];
    assign w_sum_sat  = w_sum_ovf ? colc_pkg::CNT_MAX : w_sum_wide[colc_pkg::CNT_W-1:0];

    always_comb begin
        o_result.match_total    = i_state.match_sum;
        o_result.insert_total   = i_state.insert_sum;
        o_result.softclip_total = i_state.softclip_sum;
        o_result.parse_status   = i_state.error_seen | i_state.in_digits;
        o_result.saturated      = i_state.overflow_seen;

        o_state = i_state;
        if (i_end) begin
            o_state = '0;
        end else if (i_state.error_seen) begin
            o_state = i_state;
        end else if (w_is_digit) begin
            if (w_run_wide[colc_pkg::CNT_W+3:colc_pkg::CNT_W] != 4'd0) begin
                o_state.run_length    = colc_pkg::CNT_MAX;
                o_state.overflow_seen = 1'b1;
            end else begin
                o_state.run_length = w_run_wide[colc_pkg::CNT_W-1:0];
            end
            o_state.in_digits = 1'b1;
        end else if (!i_state.in_digits) begin
            o_state.error_seen = 1'b1;
        end else begin
            case (w_op)
                colc_pkg::OP_MATCH:    o_state.match_sum    = w_sum_sat;
                colc_pkg::OP_INSERT:   o_state.insert_sum   = w_sum_sat;
                colc_pkg::OP_SOFTCLIP: o_state.softclip_sum = w_sum_sat;
                default:               ;
            endcase
            if (w_op == colc_pkg::OP_BAD) begin
                o_state.error_seen = 1'b1;
            end else begin
                if (w_op != colc_pkg::OP_SKIP) begin
                    o_state.overflow_seen = i_state.overflow_seen | w_sum_ovf;
                end
                o_state.run_length = '0;
                o_state.in_digits  = 1'b0;
            end
        end
    end

endmodule

// ===== sv/cigar_operation_length_counter_core.sv =====
// CIGAR operation length counter: one character per cycle, one result per string.
//
// The block reads a CIGAR string one character per request on the slave
// stream and closes it with a request that has tlast set (its tdata is then
// ignored). Digit runs build a run length; M, = and X add it to the match
// total, I to the insertion total, S to the soft-clip total; D, N, H and P
// close the run without adding. A token that does not start with a digit,
// an unknown operation letter, or an end right after digits flags a syntax
// error; after an error the totals and the saturation flag stay frozen.
// Run lengths and totals clamp at 2^32-1 and set the saturation flag.
// Only the end request gives a result on the master stream; the block then
// clears its counters for the next string. Throughput is one request per
// cycle while no end request waits on a stalled master side; the state
// update (multiply-by-ten add on the run length, one shared saturating add
// for the totals) is combinational. A request is registered in the input
// register, and the result of an end request in the result register. A
// stalled master side holds back an end request and the requests behind it.
`include "assert_macros.svh"

module cigar_operation_length_counter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream: characters
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [colc_pkg::CHAR_W-1:0]       i_s_axis_tdata,   // [7:0] char_code
    input  logic                              i_s_axis_tlast,   // end_of_string
    // master stream: per-string totals
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [3*colc_pkg::CNT_W-1:0]      o_m_axis_tdata,   // [31:0] match_total,
                                                                // [63:32] insert_total,
                                                                // [95:64] softclip_total
    output logic [1:0]                        o_m_axis_tuser    // [0] parse_status,
                                                                // [1] saturated
);

    // input register
    logic                         r_in_valid;
    logic [colc_pkg::CHAR_W-1:0]  r_in_char;
    logic                         r_in_end;

    // parse state
    colc_pkg::t_state             r_state;
    colc_pkg::t_state             n_state;
    colc_pkg::t_result            n_result;

    // result register
    logic                         r_out_valid;
    colc_pkg::t_result            r_out;

    logic                         w_out_free;
    logic                         w_adv;
    logic                         w_in_take;

    // Output slot is free when empty or being drained this cycle.
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    // Characters always advance; an end request needs the output slot.
    assign w_adv           = r_in_valid && (!r_in_end || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    colc_parse u_parse (
        .i_state  (r_state),
        .i_char   (r_in_char),
        .i_end    (r_in_end),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_char <= i_s_axis_tdata;
            r_in_end  <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_end) begin
            r_out <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.softclip_total, r_out.insert_total, r_out.match_total};
    assign o_m_axis_tuser  = {r_out.saturated, r_out.parse_status};

    // An end request blocked by a stalled result stays in the input register.
    `ASSERT_NEXT(a_end_held, i_clk, i_rst_n,
        r_in_valid && r_in_end && r_out_valid && !i_m_axis_tready, r_in_valid && r_in_end)
    // Counters are clear right after a string closes.
    `ASSERT_NEXT(a_clear_after_end, i_clk, i_rst_n,
        w_adv && r_in_end, r_state == '0)
    // After an error the totals stay frozen until the end request.
    `ASSERT_NEXT(a_frozen_on_error, i_clk, i_rst_n,
        r_state.error_seen && !(w_adv && r_in_end),
        $stable(r_state.match_sum) && $stable(r_state.insert_sum)
        && $stable(r_state.softclip_sum) && $stable(r_state.overflow_seen))
    // No open digit run means an empty run length.
    `ASSERT_ALWAYS(a_run_idle_zero, i_clk, i_rst_n,
        r_state.in_digits || (r_state.run_length == '0))
    // A result appears only after an end request passed the input register.
    `ASSERT_IMPL(a_out_from_end, i_clk, i_rst_n,
        $rose(r_out_valid), $past(w_adv && r_in_end))

endmodule
